// File: hw/rtl/bcsr_pkg.sv
`default_nettype none

package bcsr_pkg;

	typedef struct packed {
		logic        action;
		logic [15:0] period_ms;
		logic [15:0] rise_ms;
		logic [15:0] since_start_ms;
		logic        assist;
	} item_t;

	typedef struct packed {
		logic [9:0]  drive_speed;
		logic [19:0] pause_us;
		logic [1:0]  alarm;
		logic [1:0]  error_count;
	} result_t;

	typedef struct packed {
		logic [5:0]         breath_rate;
		logic [2:0]         ie_ratio_ref;
		logic [9:0]         init_base_speed;
		logic signed [10:0] init_ie_offset;
	} cfg_t;

	// controller -> datapath
	typedef struct packed {
		logic latch;
		logic prep;
		logic mul;
		logic ie_start;
		logic ie_update;
		logic sp_start;
		logic sp_capture;
		logic diff;
		logic mul2;
		logic base_upd;
		logic restart;
		logic fin;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic action;
		logic div_busy;
	} sts_t;

	localparam logic [1:0] REG_BREATH_RATE     = 2'd0;
	localparam logic [1:0] REG_IE_RATIO_REF    = 2'd1;
	localparam logic [1:0] REG_INIT_BASE_SPEED = 2'd2;
	localparam logic [1:0] REG_INIT_IE_OFFSET  = 2'd3;

	localparam logic ACT_CYCLE   = 1'b0;
	localparam logic ACT_RESTART = 1'b1;

	localparam logic [1:0] ALARM_NONE = 2'd0;
	localparam logic [1:0] ALARM_HIGH = 2'd1;
	localparam logic [1:0] ALARM_LOW  = 2'd2;

	localparam logic [5:0]  RST_BREATH_RATE = 6'd20;
	localparam logic [2:0]  RST_IE_RATIO    = 3'd2;
	localparam logic [9:0]  RST_INIT_BASE   = 10'd132;
	localparam logic [10:0] RST_INIT_IE     = 11'd44;

	localparam int DEN_W = 19;

	localparam logic [9:0]   SPD_MAX      = 10'd1000;
	localparam logic [19:0]  PAUSE_MAX    = 20'd1000000;
	localparam logic [16:0]  RISE_COMP    = 17'd50;
	localparam logic [28:0]  IE_GAIN      = 29'd300;
	localparam logic [23:0]  IE_CLAMP_DEN = 24'd20;
	localparam logic [4:0]   IE_CLAMP     = 5'd20;
	localparam logic [15:0]  LONG_PERIOD  = 16'd6000;
	localparam logic [9:0]   SPEED_FLOOR  = 10'd100;
	localparam logic [24:0]  PAUSE_GAIN   = 25'd500;
	localparam logic [15:0]  RATE_HIGH_MS = 16'd1200;
	localparam logic [15:0]  RATE_LOW_MS  = 16'd30000;
	localparam logic [15:0]  MIN_CHECK_MS = 16'd600;
	localparam logic [15:0]  WARMUP_MS    = 16'd2000;
	localparam logic [15:0]  SP_DIVIDEND  = 16'd60000;
	localparam logic [15:0]  DIV5_RECIP   = 16'd52429;
	localparam logic [10:0]  BASE_STEP    = 11'd5;
	localparam logic [4:0]   SP_STEPS     = 5'd16;
	localparam logic [4:0]   IE_STEPS     = 5'd5;

endpackage

`default_nettype wire

// File: hw/rtl/bcsr_regs.sv
`default_nettype none

module bcsr_regs (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            psel,
	input  wire logic            penable,
	input  wire logic            pwrite,
	input  wire logic [3:0]      paddr,
	input  wire logic [31:0]     pwdata,
	output logic [31:0]          prdata,
	output logic                 pready,
	output bcsr_pkg::cfg_t       cfg
);

	bcsr_pkg::cfg_t cfg_q;
	logic           wr;

	assign wr     = psel & penable & pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.breath_rate     <= bcsr_pkg::RST_BREATH_RATE;
			cfg_q.ie_ratio_ref    <= bcsr_pkg::RST_IE_RATIO;
			cfg_q.init_base_speed <= bcsr_pkg::RST_INIT_BASE;
			cfg_q.init_ie_offset  <= bcsr_pkg::RST_INIT_IE;
		end else if (wr) begin
			case (paddr[3:2])
				bcsr_pkg::REG_BREATH_RATE:     cfg_q.breath_rate     <= pwdata[5:0];
				bcsr_pkg::REG_IE_RATIO_REF:    cfg_q.ie_ratio_ref    <= pwdata[2:0];
				bcsr_pkg::REG_INIT_BASE_SPEED: cfg_q.init_base_speed <= pwdata[9:0];
				bcsr_pkg::REG_INIT_IE_OFFSET:  cfg_q.init_ie_offset  <= pwdata[10:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			bcsr_pkg::REG_BREATH_RATE:     prdata = {26'd0, cfg_q.breath_rate};
			bcsr_pkg::REG_IE_RATIO_REF:    prdata = {29'd0, cfg_q.ie_ratio_ref};
			bcsr_pkg::REG_INIT_BASE_SPEED: prdata = {22'd0, cfg_q.init_base_speed};
			bcsr_pkg::REG_INIT_IE_OFFSET:  prdata = {21'd0, cfg_q.init_ie_offset};
			default:                       prdata = 32'd0;
		endcase
	end

endmodule

`default_nettype wire

// File: hw/rtl/bcsr_div.sv
`default_nettype none

// Restoring divider, one quotient bit per cycle. The caller supplies the
// upper partial remainder (must be below the divisor) and the low dividend
// bits left-aligned in a 16-bit word; 'steps' bits are produced.
module bcsr_div (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic [bcsr_pkg::DEN_W-1:0]  p_init,
	input  wire logic [15:0]                 l_init,
	input  wire logic [bcsr_pkg::DEN_W-1:0]  divisor,
	input  wire logic [4:0]                  steps,
	output logic                             busy,
	output logic [15:0]                      quot
);

	logic [bcsr_pkg::DEN_W-1:0] p_q;
	logic [bcsr_pkg::DEN_W-1:0] d_q;
	logic [15:0]                l_q;
	logic [15:0]                q_q;
	logic [4:0]                 cnt_q;
	logic                       busy_q;
	logic [bcsr_pkg::DEN_W:0]   trial;
	logic [bcsr_pkg::DEN_W:0]   trial_sub;
	logic                       fits;

	assign trial     = {p_q, l_q[15]};
	assign fits      = trial >= {1'b0, d_q};
	assign trial_sub = trial - {1'b0, d_q};
	assign busy      = busy_q;
	assign quot      = q_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= steps;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 5'd1;
			if (cnt_q == 5'd1) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			p_q <= p_init;
			l_q <= l_init;
			d_q <= divisor;
			q_q <= '0;
		end else if (busy_q) begin
			p_q <= fits ? trial_sub[bcsr_pkg::DEN_W-1:0] : trial[bcsr_pkg::DEN_W-1:0];
			l_q <= {l_q[14:0], 1'b0};
			q_q <= {q_q[14:0], fits};
		end
	end

endmodule

`default_nettype wire

// File: hw/rtl/bcsr_datapath.sv
`default_nettype none

module bcsr_datapath (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire bcsr_pkg::cfg_t    cfg,
	input  wire bcsr_pkg::item_t   item,
	input  wire bcsr_pkg::cmd_t    cmd,
	output bcsr_pkg::sts_t         sts,
	output bcsr_pkg::result_t      result
);

	localparam int DW = bcsr_pkg::DEN_W;

	bcsr_pkg::item_t   item_q;
	bcsr_pkg::result_t res_q;

	logic [DW-1:0]      den_q;
	logic signed [20:0] numa_q;
	logic [27:0]        num_abs_q;
	logic               num_neg_q;
	logic [23:0]        den20_q;
	logic               sat_q;
	logic [15:0]        sp_q;
	logic               ge_q;
	logic [15:0]        diff_q;
	logic [10:0]        q40_q;
	logic [24:0]        pinc_q;
	logic [9:0]         base_q;
	logic signed [10:0] ie_q;
	logic [19:0]        pause_q;
	logic [1:0]         rerr_q;

	// shared divider
	logic               div_start;
	logic [DW-1:0]      div_p;
	logic [15:0]        div_l;
	logic [DW-1:0]      div_d;
	logic [4:0]         div_steps;
	logic               div_busy;
	logic [15:0]        div_quot;

	logic [5:0]         rate_eff;
	logic [3:0]         np1;
	logic [16:0]        rise_c;
	logic [19:0]        den_full;
	logic [20:0]        rise_prod;
	logic signed [20:0] numa;
	logic signed [20:0] numa_neg;
	logic [19:0]        numa_mag;
	logic [28:0]        num_full;
	logic [23:0]        den20_full;

	logic [4:0]         d_mag;
	logic signed [5:0]  d_s;
	logic signed [11:0] ie_sum;
	logic signed [10:0] ie_clamped;

	logic [28:0]        q5_full;
	logic [24:0]        pinc_full;

	logic               long_p;
	logic [11:0]        b_up;
	logic [9:0]         b_up_sat;
	logic [10:0]        b_dn_amt;
	logic [10:0]        b_dn_diff;
	logic [9:0]         b_dn;
	logic [25:0]        pause_sum;
	logic [19:0]        pause_cap;

	logic signed [10:0] init_ie;
	logic [9:0]         init_base;
	logic signed [10:0] init_ie_sat;

	logic               chk;
	logic               trip;
	logic [1:0]         rerr_nxt;
	logic [1:0]         alarm;
	logic [9:0]         base_f;
	logic signed [10:0] ie_f;
	logic signed [11:0] drv_sum;
	logic [9:0]         drive;

	assign rate_eff = (cfg.breath_rate == 6'd0) ? 6'd1 : cfg.breath_rate;
	assign np1      = {1'b0, cfg.ie_ratio_ref} + 4'd1;
	assign rise_c   = {1'b0, item_q.rise_ms} + bcsr_pkg::RISE_COMP;

	// I:E error: num = 300*((rise+50)*(N+1) - period), den = period*(N+1)
	assign den_full  = {4'd0, item_q.period_ms} * {16'd0, np1};
	assign rise_prod = {4'd0, rise_c} * {17'd0, np1};
	assign numa      = rise_prod - {5'd0, item_q.period_ms};
	assign numa_neg  = -numa_q;
	assign numa_mag  = numa_q[20] ? numa_neg[19:0] : numa_q[19:0];
	assign num_full  = {9'd0, numa_mag} * bcsr_pkg::IE_GAIN;
	assign den20_full = {5'd0, den_q} * bcsr_pkg::IE_CLAMP_DEN;

	// Quotient below 20 leaves num>>5 under den, so five steps suffice.
	// Zero period gives den 0 and always saturates, positive.
	assign div_start = cmd.ie_start | cmd.sp_start;
	assign div_p     = cmd.sp_start ? '0 : num_abs_q[DW+4:5];
	assign div_l     = cmd.sp_start ? bcsr_pkg::SP_DIVIDEND : {num_abs_q[4:0], 11'd0};
	assign div_d     = cmd.sp_start ? {{(DW-6){1'b0}}, rate_eff} : den_q;
	assign div_steps = cmd.sp_start ? bcsr_pkg::SP_STEPS : bcsr_pkg::IE_STEPS;

	bcsr_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.p_init  (div_p),
		.l_init  (div_l),
		.divisor (div_d),
		.steps   (div_steps),
		.busy    (div_busy),
		.quot    (div_quot)
	);

	assign d_mag  = sat_q ? bcsr_pkg::IE_CLAMP : div_quot[4:0];
	assign d_s    = num_neg_q ? -$signed({1'b0, d_mag}) : $signed({1'b0, d_mag});
	assign ie_sum = {ie_q[10], ie_q} + {{6{d_s[5]}}, d_s};

	always_comb begin
		if (ie_sum > 12'sd1000) begin
			ie_clamped = 11'sd1000;
		end else if (ie_sum < -12'sd1000) begin
			ie_clamped = -11'sd1000;
		end else begin
			ie_clamped = ie_sum[10:0];
		end
	end

	// x/40 = (x/8)/5, with x/5 by reciprocal, exact for x below 2^18
	assign q5_full   = {16'd0, diff_q[15:3]} * {13'd0, bcsr_pkg::DIV5_RECIP};
	assign pinc_full = {9'd0, diff_q} * bcsr_pkg::PAUSE_GAIN;

	assign long_p    = item_q.period_ms > bcsr_pkg::LONG_PERIOD;
	assign b_up      = {2'd0, base_q} + (long_p ? {1'b0, bcsr_pkg::BASE_STEP} : {1'b0, q40_q});
	assign b_up_sat  = (b_up > {2'd0, bcsr_pkg::SPD_MAX}) ? bcsr_pkg::SPD_MAX : b_up[9:0];
	assign b_dn_amt  = long_p ? bcsr_pkg::BASE_STEP : q40_q;
	assign b_dn_diff = {1'b0, base_q} - b_dn_amt;
	assign b_dn      = ({1'b0, base_q} >= b_dn_amt) ? b_dn_diff[9:0] : 10'd0;
	assign pause_sum = {6'd0, pause_q} + {1'b0, pinc_q};
	assign pause_cap = (pause_sum >= {6'd0, bcsr_pkg::PAUSE_MAX}) ? bcsr_pkg::PAUSE_MAX
	                                                              : pause_sum[19:0];

	assign init_ie   = cfg.init_ie_offset;
	assign init_base = (cfg.init_base_speed > bcsr_pkg::SPD_MAX) ? bcsr_pkg::SPD_MAX
	                                                             : cfg.init_base_speed;

	always_comb begin
		if (init_ie > 11'sd1000) begin
			init_ie_sat = 11'sd1000;
		end else if (init_ie < -11'sd1000) begin
			init_ie_sat = -11'sd1000;
		end else begin
			init_ie_sat = init_ie;
		end
	end

	// range check and result
	assign chk = (item_q.action == bcsr_pkg::ACT_CYCLE) && !item_q.assist &&
	             (item_q.period_ms <= bcsr_pkg::RATE_HIGH_MS ||
	              item_q.period_ms >= bcsr_pkg::RATE_LOW_MS) &&
	             (item_q.period_ms >= bcsr_pkg::MIN_CHECK_MS);
	assign trip     = chk && (rerr_q >= 2'd2);
	assign rerr_nxt = trip ? 2'd0 : (chk ? rerr_q + 2'd1 : rerr_q);
	assign alarm    = !trip ? bcsr_pkg::ALARM_NONE :
	                  (item_q.period_ms <= bcsr_pkg::RATE_HIGH_MS) ? bcsr_pkg::ALARM_HIGH
	                                                               : bcsr_pkg::ALARM_LOW;
	assign base_f   = trip ? 10'd0 : base_q;
	assign ie_f     = trip ? 11'sd0 : ie_q;
	assign drv_sum  = {2'd0, base_f} + {ie_f[10], ie_f};

	always_comb begin
		if (drv_sum < 12'sd0) begin
			drive = 10'd0;
		end else if (drv_sum > 12'sd1000) begin
			drive = bcsr_pkg::SPD_MAX;
		end else begin
			drive = drv_sum[9:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			item_q <= item;
		end
		if (cmd.prep) begin
			den_q  <= den_full[DW-1:0];
			numa_q <= numa;
		end
		if (cmd.mul) begin
			num_abs_q <= num_full[27:0];
			num_neg_q <= numa_q[20];
			den20_q   <= den20_full;
		end
		if (cmd.ie_start) begin
			sat_q <= num_abs_q >= {4'd0, den20_q};
		end
		if (cmd.sp_capture) begin
			sp_q <= div_quot;
		end
		if (cmd.diff) begin
			ge_q   <= item_q.period_ms >= sp_q;
			diff_q <= (item_q.period_ms >= sp_q) ? item_q.period_ms - sp_q
			                                     : sp_q - item_q.period_ms;
		end
		if (cmd.mul2) begin
			q40_q  <= q5_full[28:18];
			pinc_q <= pinc_full;
		end
		if (cmd.fin) begin
			res_q.drive_speed <= drive;
			res_q.pause_us    <= (item_q.action == bcsr_pkg::ACT_RESTART || item_q.assist)
			                     ? 20'd0 : pause_q;
			res_q.alarm       <= alarm;
			res_q.error_count <= rerr_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q  <= bcsr_pkg::RST_INIT_BASE;
			ie_q    <= bcsr_pkg::RST_INIT_IE;
			pause_q <= '0;
			rerr_q  <= '0;
		end else if (cmd.ie_update) begin
			if (item_q.since_start_ms > bcsr_pkg::WARMUP_MS) begin
				ie_q <= ie_clamped;
			end
		end else if (cmd.base_upd) begin
			if (ge_q) begin
				base_q <= b_up_sat;
				if (long_p) begin
					pause_q <= '0;
				end
			end else if (long_p) begin
				base_q <= b_dn;
			end else if (b_dn < bcsr_pkg::SPEED_FLOOR) begin
				// held at the floor; the shortfall turns into pause
				base_q  <= bcsr_pkg::SPEED_FLOOR;
				pause_q <= pause_cap;
			end else begin
				base_q <= b_dn;
			end
		end else if (cmd.restart) begin
			base_q <= init_base;
			ie_q   <= init_ie_sat;
		end else if (cmd.fin) begin
			rerr_q <= rerr_nxt;
			if (trip) begin
				base_q <= '0;
				ie_q   <= '0;
			end
		end
	end

	assign sts.action   = item_q.action;
	assign sts.div_busy = div_busy;
	assign result       = res_q;

endmodule

`default_nettype wire

// File: hw/rtl/bcsr_ctrl.sv
`default_nettype none

module bcsr_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            item_valid,
	output logic                 item_ready,
	output logic                 result_valid,
	input  wire logic            result_ready,
	input  wire bcsr_pkg::sts_t  sts,
	output bcsr_pkg::cmd_t       cmd
);

	typedef enum logic [11:0] {
		ST_IDLE     = 12'b0000_0000_0001,
		ST_PREP     = 12'b0000_0000_0010,
		ST_MUL      = 12'b0000_0000_0100,
		ST_IE_START = 12'b0000_0000_1000,
		ST_IE_WAIT  = 12'b0000_0001_0000,
		ST_SP_START = 12'b0000_0010_0000,
		ST_SP_WAIT  = 12'b0000_0100_0000,
		ST_DIFF     = 12'b0000_1000_0000,
		ST_MUL2     = 12'b0001_0000_0000,
		ST_BASE     = 12'b0010_0000_0000,
		ST_RESTART  = 12'b0100_0000_0000,
		ST_FIN      = 12'b1000_0000_0000
	} state_t;

	state_t state_q;
	state_t state_nxt;
	logic   out_valid_q;

	assign item_ready   = (state_q == ST_IDLE);
	assign result_valid = out_valid_q;

	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (item_valid) begin
					cmd.latch = 1'b1;
					state_nxt = ST_PREP;
				end
			end
			ST_PREP: begin
				cmd.prep  = 1'b1;
				state_nxt = (sts.action == bcsr_pkg::ACT_RESTART) ? ST_RESTART : ST_MUL;
			end
			ST_MUL: begin
				cmd.mul   = 1'b1;
				state_nxt = ST_IE_START;
			end
			ST_IE_START: begin
				cmd.ie_start = 1'b1;
				state_nxt    = ST_IE_WAIT;
			end
			ST_IE_WAIT: begin
				if (!sts.div_busy) begin
					cmd.ie_update = 1'b1;
					state_nxt     = ST_SP_START;
				end
			end
			ST_SP_START: begin
				cmd.sp_start = 1'b1;
				state_nxt    = ST_SP_WAIT;
			end
			ST_SP_WAIT: begin
				if (!sts.div_busy) begin
					cmd.sp_capture = 1'b1;
					state_nxt      = ST_DIFF;
				end
			end
			ST_DIFF: begin
				cmd.diff  = 1'b1;
				state_nxt = ST_MUL2;
			end
			ST_MUL2: begin
				cmd.mul2  = 1'b1;
				state_nxt = ST_BASE;
			end
			ST_BASE: begin
				cmd.base_upd = 1'b1;
				state_nxt    = ST_FIN;
			end
			ST_RESTART: begin
				cmd.restart = 1'b1;
				state_nxt   = ST_FIN;
			end
			ST_FIN: begin
				// commit only once the result slot is free
				if (!out_valid_q || result_ready) begin
					cmd.fin   = 1'b1;
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.fin) begin
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

`ifndef SYNTHESIS
	a_fin_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fin |=> result_valid)
		else $error("result not presented after commit");

	a_one_item_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && item_ready) |=> !item_ready)
		else $error("item taken while another is in work");

	a_div_runs: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.ie_start || cmd.sp_start) |=> sts.div_busy)
		else $error("divider did not start");

	a_fin_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !result_ready) |-> !cmd.fin)
		else $error("result overwritten while waiting");
`endif

endmodule

`default_nettype wire

// File: hw/rtl/breath_cycle_speed_regulator.sv
`default_nettype none

// channel   dir  handshake                  payload
// item      in   item_valid / item_ready    item   (bcsr_pkg::item_t)
// result    out  result_valid / result_ready result (bcsr_pkg::result_t)
// config    in   APB psel/penable/pwrite    paddr[3:0], pwdata, prdata
//
// A breath item runs two passes of the shared restoring divider (5 bits of
// I:E error, 16 bits of setpoint period) between acceptances; a restart
// item skips both passes.
// The result register holds its item until taken; the next item is worked
// meanwhile and waits only at the final commit.
// arst_n clears control, loads the default registers and speeds.

module breath_cycle_speed_regulator (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                item_valid,
	output logic                     item_ready,
	input  wire bcsr_pkg::item_t     item,
	output logic                     result_valid,
	input  wire logic                result_ready,
	output bcsr_pkg::result_t        result,
	input  wire logic                psel,
	input  wire logic                penable,
	input  wire logic                pwrite,
	input  wire logic [3:0]          paddr,
	input  wire logic [31:0]         pwdata,
	output logic [31:0]              prdata,
	output logic                     pready
);

	bcsr_pkg::cfg_t cfg;
	bcsr_pkg::cmd_t cmd;
	bcsr_pkg::sts_t sts;

	bcsr_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	bcsr_datapath u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.item   (item),
		.cmd    (cmd),
		.sts    (sts),
		.result (result)
	);

	bcsr_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.sts          (sts),
		.cmd          (cmd)
	);

endmodule

`default_nettype wire

// File: verif/testbench.sv
`default_nettype none

module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	// arithmetic constants of the regulator, kept signed for the predictor
	localparam longint SPEED_CEIL   = 1000;
	localparam longint OFFSET_CEIL  = 1000;
	localparam longint PAUSE_CEIL   = 1000000;
	localparam longint RISE_ADD     = 50;
	localparam longint IE_K         = 300;
	localparam longint IE_LIM       = 20;
	localparam longint PER_DIV      = 40;
	localparam longint LONG_MS      = 6000;
	localparam longint FLOOR_SPD    = 100;
	localparam longint PAUSE_K      = 500;
	localparam longint HIGH_RATE_MS = 1200;
	localparam longint LOW_RATE_MS  = 30000;
	localparam longint CHECK_MIN_MS = 600;
	localparam longint WARM_MS      = 2000;

	localparam int STALL_LIMIT = 3000;
	localparam int TAIL_CYCLES = 60;

	logic              clk;
	logic              arst_n = 1'b0;
	logic              item_valid = 1'b0;
	logic              item_ready;
	bcsr_pkg::item_t   tx_item = '0;
	logic              result_valid;
	logic              result_ready = 1'b0;
	bcsr_pkg::result_t rx_result;
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [3:0]        paddr = '0;
	logic [31:0]       pwdata = '0;
	logic [31:0]       prdata;
	logic              pready;

	breath_cycle_speed_regulator uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (tx_item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (rx_result),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	// predictor copy of registers and state
	logic [5:0]  cfg_rate;
	logic [2:0]  cfg_ie;
	logic [9:0]  cfg_base;
	logic [10:0] cfg_ofs;
	longint      base_spd;
	longint      ie_ofs;
	longint      pause_acc;
	int          range_err;

	bcsr_pkg::result_t stroke_q[$];
	int          mismatches = 0;
	int          results_seen = 0;
	int          idle_cycles = 0;
	int          burst_left = 0;
	int          oor_run = 0;
	bit          rx_stall_en = 1'b1;
	bit          tx_gaps_en = 1'b1;
	bit          rx_hold = 1'b0;
	int          rx_run = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic longint clip(longint v, longint lo, longint hi);
		if (v < lo)
			return lo;
		if (v > hi)
			return hi;
		return v;
	endfunction

	function automatic void load_speeds();
		base_spd = clip(longint'(cfg_base), 0, SPEED_CEIL);
		ie_ofs = clip(longint'($signed(cfg_ofs)), -OFFSET_CEIL, OFFSET_CEIL);
	endfunction

	function automatic void model_reset();
		cfg_rate = bcsr_pkg::RST_BREATH_RATE;
		cfg_ie = bcsr_pkg::RST_IE_RATIO;
		cfg_base = bcsr_pkg::RST_INIT_BASE;
		cfg_ofs = bcsr_pkg::RST_INIT_IE;
		load_speeds();
		pause_acc = 0;
		range_err = 0;
	endfunction

	// one breath (or restart) through the speed regulator
	function automatic bcsr_pkg::result_t compute_stroke(bcsr_pkg::item_t it);
		bcsr_pkg::result_t r;
		longint per, rise, since, rate, np1, sp, b, d, num, diff, p;
		logic [1:0] alm;
		longint pout;
		per = it.period_ms;
		rise = it.rise_ms;
		since = it.since_start_ms;
		alm = bcsr_pkg::ALARM_NONE;
		pout = 0;
		if (it.action == bcsr_pkg::ACT_RESTART) begin
			load_speeds();
		end else begin
			rate = cfg_rate;
			if (rate == 0)
				rate = 1;
			np1 = cfg_ie;
			np1 = np1 + 1;
			sp = 60000 / rate;
			b = base_spd;
			if (since > WARM_MS) begin
				if (per == 0) begin
					d = IE_LIM;
				end else begin
					num = IE_K * ((rise + RISE_ADD) * np1 - per);
					d = num / (per * np1);
					if (d >= IE_LIM)
						d = IE_LIM;
					if (d <= -IE_LIM)
						d = -IE_LIM;
				end
				ie_ofs = clip(ie_ofs + d, -OFFSET_CEIL, OFFSET_CEIL);
			end
			if (per >= sp) begin
				if (per > LONG_MS) begin
					b = b + 5;
					pause_acc = 0;
				end else begin
					b = b + (per - sp) / PER_DIV;
				end
				base_spd = clip(b, 0, SPEED_CEIL);
			end else if (per > LONG_MS) begin
				base_spd = clip(b - 5, 0, SPEED_CEIL);
			end else begin
				diff = sp - per;
				b = clip(b - diff / PER_DIV, 0, SPEED_CEIL);
				if (b < FLOOR_SPD) begin
					p = pause_acc + diff * PAUSE_K;
					b = FLOOR_SPD;
					if (p >= PAUSE_CEIL)
						p = PAUSE_CEIL;
					pause_acc = p;
				end
				base_spd = b;
			end
			if ((per <= HIGH_RATE_MS || per >= LOW_RATE_MS) && per >= CHECK_MIN_MS &&
					!it.assist) begin
				if (range_err >= 2) begin
					range_err = 0;
					alm = (per <= HIGH_RATE_MS) ? bcsr_pkg::ALARM_HIGH
						: bcsr_pkg::ALARM_LOW;
					base_spd = 0;
					ie_ofs = 0;
				end else begin
					range_err++;
				end
			end
			pout = it.assist ? 0 : pause_acc;
		end
		r.drive_speed = 10'(clip(base_spd + ie_ofs, 0, SPEED_CEIL));
		r.pause_us = 20'(pout);
		r.alarm = alm;
		r.error_count = 2'(range_err);
		return r;
	endfunction

	function automatic bcsr_pkg::item_t mk(logic act, int per, int rise, int since,
			logic asst);
		bcsr_pkg::item_t it;
		it.action = act;
		it.period_ms = 16'(per);
		it.rise_ms = 16'(rise);
		it.since_start_ms = 16'(since);
		it.assist = asst;
		return it;
	endfunction

	// mostly plausible breaths near the setpoint, runs of out-of-range periods,
	// some restarts and some raw noise
	function automatic bcsr_pkg::item_t gen_breath();
		bcsr_pkg::item_t it;
		int sp, per, rise, k;
		sp = 60000 / ((cfg_rate == 0) ? 1 : int'(cfg_rate));
		k = $urandom_range(0, 99);
		it = mk(bcsr_pkg::ACT_CYCLE, 0, 0, $urandom_range(2001, 65535), 1'b0);
		if (oor_run > 0 || (k >= 12 && k < 20)) begin
			oor_run = (oor_run > 0) ? oor_run - 1 : 2;
			it.period_ms = $urandom_range(0, 1) ? 16'($urandom_range(600, 1200)) :
				16'($urandom_range(30000, 65535));
			it.rise_ms = 16'($urandom_range(0, 3000));
			// now and then a sequence is broken by an assisted breath
			it.assist = ($urandom_range(0, 9) == 0);
		end else if (k < 4) begin
			it = 50'($urandom) ^ {$urandom, 18'($urandom)};
			it.action = bcsr_pkg::ACT_RESTART;
		end else if (k < 12) begin
			it = {$urandom, 18'($urandom)};
			it.action = bcsr_pkg::ACT_CYCLE;
		end else begin
			per = sp + $urandom_range(0, 1600) - 800;
			per = (per < 0) ? 0 : (per > 65535) ? 65535 : per;
			rise = per / (int'(cfg_ie) + 1) - 50 + $urandom_range(0, 300) - 150;
			rise = (rise < 0) ? 0 : (rise > 65535) ? 65535 : rise;
			it.period_ms = 16'(per);
			it.rise_ms = 16'(rise);
			if ($urandom_range(0, 99) < 15)
				it.since_start_ms = 16'($urandom_range(0, 2500));
			it.assist = ($urandom_range(0, 9) == 0);
		end
		return it;
	endfunction

	task automatic flag_mismatch(input string what, input longint got, input longint want);
		if (mismatches < 40)
			$display("mismatch %s at result %0d: got %0d, expected %0d",
				what, results_seen, got, want);
		mismatches++;
	endtask

	task automatic send_item(input bcsr_pkg::item_t it);
		bcsr_pkg::item_t tmp;
		tmp = it;
		tx_item <= tmp;
		item_valid <= 1'b1;
		do
			@(posedge clk);
		while (!item_ready);
		stroke_q.push_back(compute_stroke(tmp));
	endtask

	task automatic pause_sender(input int n);
		item_valid <= 1'b0;
		tx_item <= {$urandom, 18'($urandom)};
		repeat (n) @(posedge clk);
	endtask

	task automatic wait_drained();
		item_valid <= 1'b0;
		@(posedge clk);
		while (stroke_q.size() != 0)
			@(posedge clk);
		@(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] value, input int w);
		logic [31:0] data, mask;
		mask = (32'd1 << w) - 1;
		data = $urandom_range(0, 1) ? (($urandom & ~mask) | (value & mask)) : (value & mask);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		case (idx)
			bcsr_pkg::REG_BREATH_RATE:     cfg_rate = data[5:0];
			bcsr_pkg::REG_IE_RATIO_REF:    cfg_ie = data[2:0];
			bcsr_pkg::REG_INIT_BASE_SPEED: cfg_base = data[9:0];
			bcsr_pkg::REG_INIT_IE_OFFSET:  cfg_ofs = data[10:0];
			default: ;
		endcase
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic apply_setting(input int rate, input int ie, input int base, input int ofs);
		wait_drained();
		write_reg(bcsr_pkg::REG_BREATH_RATE, 32'(rate), 6);
		write_reg(bcsr_pkg::REG_IE_RATIO_REF, 32'(ie), 3);
		write_reg(bcsr_pkg::REG_INIT_BASE_SPEED, 32'(base), 10);
		write_reg(bcsr_pkg::REG_INIT_IE_OFFSET, 32'(ofs), 11);
	endtask

	task automatic run_traffic(input int n);
		int gap;
		for (int i = 0; i < n; i++) begin
			if (burst_left <= 0) begin
				burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80) :
					$urandom_range(1, 12);
				gap = ($urandom_range(0, 4) == 0 || !tx_gaps_en) ? 0 : $urandom_range(1, 40);
				if (gap > 0)
					pause_sender(gap);
			end
			send_item(gen_breath());
			burst_left--;
		end
	endtask

	task automatic test_directed_cases();
		send_item(mk(bcsr_pkg::ACT_RESTART, 65535, 65535, 65535, 1'b1));
		// zero period: full positive I:E step, floor hit, pause saturates
		send_item(mk(bcsr_pkg::ACT_CYCLE, 0, 0, 65535, 1'b0));
		// very long period: +5 and pause cleared
		send_item(mk(bcsr_pkg::ACT_CYCLE, 65535, 65535, 65535, 1'b1));
		send_item(mk(bcsr_pkg::ACT_CYCLE, 3000, 950, 2001, 1'b0));
		send_item(mk(bcsr_pkg::ACT_CYCLE, 3000, 1000, 2000, 1'b0));
		send_item(mk(bcsr_pkg::ACT_CYCLE, 2999, 0, 3000, 1'b0));
		send_item(mk(bcsr_pkg::ACT_CYCLE, 1, 65535, 65535, 1'b0));
		send_item(mk(bcsr_pkg::ACT_CYCLE, 3040, 1063, 9000, 1'b1));
		// three fast breaths in a row raise the high-rate alarm
		repeat (3) send_item(mk(bcsr_pkg::ACT_CYCLE, 1200, 300, 5000, 1'b0));
		send_item(mk(bcsr_pkg::ACT_CYCLE, 599, 100, 5000, 1'b0));
		send_item(mk(bcsr_pkg::ACT_CYCLE, 600, 100, 5000, 1'b0));
		send_item(mk(bcsr_pkg::ACT_CYCLE, 1201, 300, 5000, 1'b0));
		send_item(mk(bcsr_pkg::ACT_CYCLE, 29999, 8000, 5000, 1'b0));
		send_item(mk(bcsr_pkg::ACT_CYCLE, 30000, 8000, 5000, 1'b0));
		send_item(mk(bcsr_pkg::ACT_CYCLE, 65535, 8000, 5000, 1'b1));
		send_item(mk(bcsr_pkg::ACT_CYCLE, 40000, 8000, 5000, 1'b0));
		send_item(mk(bcsr_pkg::ACT_RESTART, 0, 0, 0, 1'b0));
		// long setpoint: a short-of-setpoint period above 6000 and one at 6000
		wait_drained();
		write_reg(bcsr_pkg::REG_BREATH_RATE, 32'd2, 6);
		send_item(mk(bcsr_pkg::ACT_CYCLE, 6001, 2000, 65535, 1'b0));
		send_item(mk(bcsr_pkg::ACT_CYCLE, 6000, 2000, 65535, 1'b0));
		wait_drained();
		write_reg(bcsr_pkg::REG_BREATH_RATE, 32'(bcsr_pkg::RST_BREATH_RATE), 6);
	endtask

	task automatic test_config_settings();
		int rate[7] = '{2, 50, 0, 63, 1, 37, 20};
		int ie[7]   = '{1, 4, 0, 7, 3, 5, 2};
		int base[7] = '{1023, 0, 500, 1000, 100, 700, 132};
		int ofs[7]  = '{1000, 11'h400, 0, -1000, -1, 1023, 44};
		for (int s = 0; s < 7; s++) begin
			apply_setting(rate[s], ie[s], base[s], ofs[s]);
			send_item(mk(bcsr_pkg::ACT_RESTART, $urandom, $urandom, $urandom,
				$urandom_range(0, 1)));
			send_item(mk(bcsr_pkg::ACT_CYCLE, 65535, 0, 0, 1'b0));
			send_item(mk(bcsr_pkg::ACT_CYCLE, 0, 0, 65535, 1'b0));
			send_item(mk(bcsr_pkg::ACT_CYCLE, 6001, 0, 65535, 1'b0));
			run_traffic(125);
		end
	endtask

	task automatic test_random_traffic();
		for (int c = 0; c < 4; c++) begin
			apply_setting($urandom_range(0, 63), $urandom_range(0, 7), $urandom_range(0, 1023),
				$urandom_range(0, 2047));
			rx_stall_en = (c != 1);
			tx_gaps_en = (c != 1);
			send_item(mk(bcsr_pkg::ACT_RESTART, $urandom, $urandom, $urandom,
				$urandom_range(0, 1)));
			run_traffic(75);
			// hold the sender until the block has delivered everything
			wait_drained();
			run_traffic(80);
		end
		rx_stall_en = 1'b1;
		tx_gaps_en = 1'b1;
	endtask

	// receiver: alternating ready and stall runs, occasionally long stalls
	always @(posedge clk) begin
		if (rx_run == 0) begin
			rx_hold = !rx_hold;
			if (rx_hold)
				rx_run = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) :
					$urandom_range(1, 6);
			else
				rx_run = $urandom_range(1, 24);
		end else begin
			rx_run--;
		end
		result_ready <= !rx_stall_en || !rx_hold;
	end

	always @(posedge clk) begin
		bcsr_pkg::result_t want;
		if (arst_n && result_valid && result_ready) begin
			if (stroke_q.size() == 0) begin
				flag_mismatch("unexpected result", rx_result, 0);
			end else begin
				want = stroke_q.pop_front();
				if (rx_result.drive_speed !== want.drive_speed)
					flag_mismatch("drive_speed", rx_result.drive_speed, want.drive_speed);
				if (rx_result.pause_us !== want.pause_us)
					flag_mismatch("pause_us", rx_result.pause_us, want.pause_us);
				if (rx_result.alarm !== want.alarm)
					flag_mismatch("alarm", rx_result.alarm, want.alarm);
				if (rx_result.error_count !== want.error_count)
					flag_mismatch("error_count", rx_result.error_count, want.error_count);
			end
			results_seen++;
		end
	end

	always @(posedge clk) begin
		if ((item_valid && item_ready) || (result_valid && result_ready) || (psel && penable))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin
		@(posedge clk);
		while (idle_cycles < STALL_LIMIT)
			@(posedge clk);
		$display("TB_ERROR");
		$finish;
	end

	initial begin
		model_reset();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_cases();
		test_config_settings();
		test_random_traffic();
		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (stroke_q.size() != 0)
			flag_mismatch("missing results", stroke_q.size(), 0);
		if (mismatches == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

`default_nettype wire
